// ===== sv/sdsi_pkg.sv =====
package sdsi_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CLOCKS, PH_SELECT, PH_FRAME, PH_RESP, PH_DATA, PH_RELEASE
  } phase_t;

  typedef enum logic [2:0] {
    C_CMD0, C_CMD8, C_HCS, C_CMD58, C_PROBE, C_SD1, C_CMD1, C_CMD16
  } ctx_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0, KIND_MMC = 3'd1, KIND_SD1 = 3'd2, KIND_SD2 = 3'd3, KIND_SDHC = 3'd4
  } kind_t;

  localparam logic       OP_START    = 1'b0;
  localparam int         IDLE_BYTES  = 10;
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [5:0] IDX_CMD0    = 6'd0;
  localparam logic [5:0] IDX_CMD1    = 6'd1;
  localparam logic [5:0] IDX_CMD8    = 6'd8;
  localparam logic [5:0] IDX_CMD16   = 6'd16;
  localparam logic [5:0] IDX_ACMD41  = 6'd41;
  localparam logic [5:0] IDX_CMD55   = 6'd55;
  localparam logic [5:0] IDX_CMD58   = 6'd58;

  // CRC7 over the five leading frame bytes, returned as the closing byte.
  function automatic logic [7:0] crc7_byte(input logic [39:0] bits);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = bits[i] ^ crc[6];
      crc = {crc[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
    end
    return {crc, 1'b1};
  endfunction

endpackage

// ===== sv/sd_spi_card_init_sequencer.sv =====
// SD/MMC card initialisation sequencer for SPI mode (host side).
// The input channel carries one transfer per byte event: op = 0 starts the
// initialisation, op = 1 reports that a byte exchange completed, with the
// byte received in rx_byte. Each accepted input produces exactly one result
// transfer: the next byte to clock out with chip select level, fast clock
// flag, pause request, and at the end done_res with the card kind.
// The sequence is ten idle bytes, a ready poll, CMD0, CMD8, ACMD41 (with
// CMD55 prefix) or CMD1 polling, CMD58 and CMD16 as the card requires.
// A result appears in the output register on the cycle after its input
// transfer. One input can be accepted every cycle while in_stall is low;
// the limit is the single state update and result register.
// When the receiver stalls, the result is held and in_stall is raised only
// while the output register is full and stalled, so no result is lost.
// Reset (rst_n low, synchronous) returns to idle, clears the poll counters
// and the card kind, and loads retry_limit with its default of 50000.
// The frame and OCR stores need no reset as they are written before use.
module sd_spi_card_init_sequencer #(
  parameter int RESPONSE_TRIES = 10,
  parameter int BLOCK_LENGTH   = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_retry_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_cs_high,
  output logic        out_fast_rate,
  output logic        out_pause_first,
  output logic        out_done_res,
  output logic [2:0]  out_card_kind
);
  import sdsi_pkg::*;

  localparam int RW = (RESPONSE_TRIES > 1) ? $clog2(RESPONSE_TRIES + 1) : 1;
  localparam int CW = (RW > 4) ? RW : 4;

  logic [15:0] retry_r;
  phase_t      phase_r, phase_nxt;
  ctx_t        ctx_r, ctx_nxt;
  logic [7:0]  frame_r [6];
  logic [7:0]  frame_nxt [6];
  logic        frame_we;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [CW-1:0] resp_r, resp_nxt;
  logic [7:0]  ocr_r [4];
  logic [2:0]  kind_r, kind_nxt;
  logic        pre_r, pre_nxt;
  logic        fast_r, fast_nxt;

  logic        acc;
  logic [15:0] lim;
  logic [15:0] poll_inc;
  logic [CW-1:0] resp_inc;
  logic [7:0]  o_tx;
  logic        o_cs, o_pause, o_done;

  // Output register.
  logic        ov_r;
  logic [7:0]  tx_r;
  logic        cs_r, fr_r, pa_r, dn_r;
  logic [2:0]  ck_r;

  assign in_stall = ov_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign lim      = (retry_r == 16'd0) ? 16'd1 : retry_r;
  assign poll_inc = poll_r + 16'd1;
  assign resp_inc = resp_r + CW'(1);

  always_comb begin
    logic [5:0]  code;
    logic [31:0] arg;
    logic        bld;
    ctx_t        which;
    logic        begin_c;
    logic        bpause;
    logic        main_f;
    logic [7:0]  res;
    logic        handled;

    phase_nxt = phase_r;
    ctx_nxt   = ctx_r;
    idx_nxt   = idx_r;
    poll_nxt  = poll_r;
    resp_nxt  = resp_r;
    kind_nxt  = kind_r;
    pre_nxt   = pre_r;
    fast_nxt  = fast_r;
    o_tx = BYTE_IDLE; o_cs = 1'b1; o_pause = 1'b0; o_done = 1'b0;
    begin_c = 1'b0; bpause = 1'b0; which = ctx_r; main_f = 1'b0;
    res = in_rx_byte; handled = 1'b0;
    code = IDX_CMD0; arg = '0; bld = 1'b0;

    if (in_op == OP_START) begin
      kind_nxt = KIND_NONE; fast_nxt = 1'b0; pre_nxt = 1'b0;
      resp_nxt = '0; phase_nxt = PH_CLOCKS;
    end else begin
      unique case (phase_r)
        PH_CLOCKS: begin
          resp_nxt = resp_inc;
          if (resp_inc < CW'(IDLE_BYTES)) begin
            o_cs = 1'b1;
          end else begin
            phase_nxt = PH_SELECT; poll_nxt = '0; o_cs = 1'b0;
          end
        end
        PH_SELECT: begin
          if (res == BYTE_IDLE) begin
            begin_c = 1'b1; which = C_CMD0;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc < lim) begin
              o_cs = 1'b0; o_pause = 1'b1;
            end else begin
              phase_nxt = PH_RELEASE; o_pause = 1'b1;
            end
          end
        end
        PH_FRAME: begin
          idx_nxt = idx_r + 3'd1;
          o_cs = 1'b0;
          if (idx_r < 3'd5) begin
            o_tx = frame_r[idx_r + 3'd1];
          end else begin
            phase_nxt = PH_RESP; resp_nxt = '0;
          end
        end
        PH_RESP: begin
          resp_nxt = resp_inc;
          o_cs = 1'b0;
          if (res != BYTE_IDLE || resp_inc >= CW'(RESPONSE_TRIES)) begin
            if (pre_r) begin
              pre_nxt = 1'b0;
              if (res <= 8'd1) begin
                main_f = 1'b1; handled = 1'b1;
              end
            end
            if (!handled) begin
              unique case (ctx_r)
                C_CMD0: begin
                  if (res <= 8'd1) begin
                    fast_nxt = 1'b1; begin_c = 1'b1; which = C_CMD8;
                  end else phase_nxt = PH_RELEASE;
                end
                C_CMD8: begin
                  if (res <= 8'd1) begin
                    phase_nxt = PH_DATA; idx_nxt = '0;
                  end else begin
                    begin_c = 1'b1; which = C_PROBE;
                  end
                end
                C_CMD58: begin
                  if (res == 8'd0) begin
                    phase_nxt = PH_DATA; idx_nxt = '0;
                  end else phase_nxt = PH_RELEASE;
                end
                C_PROBE: begin
                  poll_nxt = '0; begin_c = 1'b1;
                  which = (res <= 8'd1) ? C_SD1 : C_CMD1;
                end
                C_HCS, C_SD1, C_CMD1: begin
                  if (res == 8'd1) begin
                    poll_nxt = poll_inc;
                    if (poll_inc < lim) begin
                      begin_c = 1'b1; which = ctx_r; bpause = 1'b1;
                    end else begin
                      phase_nxt = PH_RELEASE; o_pause = 1'b1;
                    end
                  end else if (res == 8'd0) begin
                    begin_c = 1'b1;
                    if (ctx_r == C_HCS) which = C_CMD58;
                    else begin
                      which = C_CMD16;
                      kind_nxt = (ctx_r == C_SD1) ? KIND_SD1 : KIND_MMC;
                    end
                  end else phase_nxt = PH_RELEASE;
                end
                default: phase_nxt = PH_RELEASE;
              endcase
            end
          end
        end
        PH_DATA: begin
          idx_nxt = idx_r + 3'd1;
          o_cs = 1'b0;
          if (idx_r >= 3'd3) begin
            if (ctx_r == C_CMD8) begin
              if (ocr_r[2] == 8'h01 && res == 8'hAA) begin
                poll_nxt = '0; begin_c = 1'b1; which = C_HCS;
              end else begin
                phase_nxt = PH_RELEASE; o_cs = 1'b1;
              end
            end else if (ocr_r[0][6]) begin
              kind_nxt = KIND_SDHC; phase_nxt = PH_RELEASE; o_cs = 1'b1;
            end else begin
              kind_nxt = KIND_SD2; begin_c = 1'b1; which = C_CMD16;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE; o_done = 1'b1;
        end
      endcase
      if (phase_nxt == PH_RELEASE && phase_r != PH_RELEASE) o_cs = 1'b1;
    end

    if (begin_c) begin
      ctx_nxt = which;
      if (which == C_HCS || which == C_PROBE || which == C_SD1) begin
        pre_nxt = 1'b1; code = IDX_CMD55; arg = '0; bld = 1'b1;
      end else begin
        pre_nxt = 1'b0; main_f = 1'b1;
      end
    end
    if (main_f) begin
      bld = 1'b1;
      unique case (begin_c ? which : ctx_r)
        C_CMD0:  begin code = IDX_CMD0;   arg = '0; end
        C_CMD8:  begin code = IDX_CMD8;   arg = 32'h1AA; end
        C_HCS:   begin code = IDX_ACMD41; arg = 32'h4000_0000; end
        C_CMD58: begin code = IDX_CMD58;  arg = '0; end
        C_PROBE, C_SD1: begin code = IDX_ACMD41; arg = '0; end
        C_CMD1:  begin code = IDX_CMD1;   arg = '0; end
        default: begin code = IDX_CMD16;  arg = 32'(BLOCK_LENGTH); end
      endcase
    end
    frame_we = bld;
    frame_nxt[0] = {2'b01, code};
    frame_nxt[1] = arg[31:24];
    frame_nxt[2] = arg[23:16];
    frame_nxt[3] = arg[15:8];
    frame_nxt[4] = arg[7:0];
    frame_nxt[5] = crc7_byte({2'b01, code, arg});
    if (bld) begin
      phase_nxt = PH_FRAME; idx_nxt = '0;
      o_tx = {2'b01, code}; o_cs = 1'b0; o_pause = bpause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r <= 16'd50000;
      phase_r <= PH_IDLE;
      ctx_r   <= C_CMD0;
      idx_r   <= '0;
      poll_r  <= '0;
      resp_r  <= '0;
      kind_r  <= KIND_NONE;
      pre_r   <= 1'b0;
      fast_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) retry_r <= cfg_retry_limit;
      if (acc) begin
        phase_r <= phase_nxt;
        ctx_r   <= ctx_nxt;
        idx_r   <= idx_nxt;
        poll_r  <= poll_nxt;
        resp_r  <= resp_nxt;
        kind_r  <= kind_nxt;
        pre_r   <= pre_nxt;
        fast_r  <= fast_nxt;
        ov_r    <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (frame_we) begin
        for (int i = 0; i < 6; i++) frame_r[i] <= frame_nxt[i];
      end
      if (in_op != OP_START && phase_r == PH_DATA) ocr_r[idx_r[1:0]] <= in_rx_byte;
      tx_r <= o_tx;
      cs_r <= o_cs;
      fr_r <= fast_nxt;
      pa_r <= o_pause;
      dn_r <= o_done;
      ck_r <= o_done ? kind_r : KIND_NONE;
    end
  end

  assign out_valid       = ov_r;
  assign out_tx_byte     = tx_r;
  assign out_cs_high     = cs_r;
  assign out_fast_rate   = fr_r;
  assign out_pause_first = pa_r;
  assign out_done_res    = dn_r;
  assign out_card_kind   = ck_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid) else $error("accepted transfer gave no result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte))
    else $error("stalled result changed");
  a_kind_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_card_kind == 3'd0)
    else $error("card kind outside done result");
  a_done_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_cs_high) else $error("done with card selected");
endmodule
